// ===== rtl/core/pkbc_pkg.sv =====
`timescale 1ns / 1ps

package pkbc_pkg;

   // field widths
   localparam int DATA_W = 8;
   localparam int KEY_W  = 32;
   localparam int SEL_W  = 2;
   localparam int WORD_W = 32;
   localparam int FIB_W  = 16;

   // generator constants
   localparam logic [WORD_W-1:0] GALOIS_TAPS    = 32'hD000_0001;
   localparam logic [WORD_W-1:0] LCG_MUL        = 32'd1103515245;
   localparam logic [WORD_W-1:0] LCG_ADD        = 32'd12345;
   localparam logic [WORD_W-1:0] GALOIS_DEFAULT = 32'h0000_0001;
   localparam logic [WORD_W-1:0] LCG_DEFAULT    = 32'h0000_0000;
   localparam logic [FIB_W-1:0]  FIB_DEFAULT    = 16'hACE1;
   localparam logic [DATA_W-1:0] KS_MODULUS     = 8'hFF;

   // generator choice; the unused code behaves as the Fibonacci generator
   typedef enum logic [SEL_W-1:0] {
      GEN_GALOIS = 2'd0,
      GEN_LCG    = 2'd1,
      GEN_FIB    = 2'd2
   } gen_sel_type;

   // byte operation
   typedef enum logic {
      FUNC_CRYPT     = 1'b0,
      FUNC_RANDOMIZE = 1'b1
   } func_type;

   // transaction held between generator stage and output stage
   typedef struct packed {
      logic              func;
      logic [DATA_W-1:0] data;
      logic [WORD_W-1:0] word;
   } stage_type;

   // one step of the 16-bit Fibonacci LFSR, taps 16 14 13 11
   function automatic logic [FIB_W-1:0] fib_once(input logic [FIB_W-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[FIB_W-1:1]};
   endfunction

endpackage

// ===== rtl/core/pkbc_if.sv =====
`timescale 1ns / 1ps

// request channel: one byte transaction
interface pkbc_req_if
   import pkbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              func;
   logic              new_message;
   logic [KEY_W-1:0]  key;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, func, new_message, key, data_in, input ready);
   modport sink   (input valid, func, new_message, key, data_in, output ready);
endinterface

// response channel: one transformed byte
interface pkbc_rsp_if
   import pkbc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;

   modport source (output valid, data_out, input ready);
   modport sink   (input valid, data_out, output ready);
endinterface

// register write channel: generator_select
interface pkbc_csr_if
   import pkbc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/pkbc_keygen.sv =====
`timescale 1ns / 1ps

module pkbc_keygen
   import pkbc_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   pkbc_req_if.sink      req,
   pkbc_csr_if.sink      csr,
   output logic          stage_valid,
   output stage_type     stage,
   input  logic          stage_ready
   );

   gen_sel_type       sel_ff, sel_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;

   logic              accept;
   logic              reseed;
   logic [WORD_W-1:0] base;
   logic [WORD_W-1:0] lcg_prod;
   logic [FIB_W-1:0]  fib_a;
   logic [FIB_W-1:0]  fib_b;
   logic [WORD_W-1:0] next_seed;
   logic [WORD_W-1:0] word;

   // handshakes
   assign csr.ready = 1'b1;
   assign req.ready = !s1_valid_ff || stage_ready;
   assign accept    = req.valid && req.ready;

   // seed source: key on the first crypt byte of a message
   assign reseed = (req.func == FUNC_CRYPT) && req.new_message;

   always_comb begin
      base = seed_ff;
      if (reseed) begin
         if (sel_ff == GEN_GALOIS || sel_ff == GEN_LCG) begin
            base = req.key;
         end else begin
            base = {{(WORD_W-FIB_W){1'b0}}, req.key[FIB_W-1:0]};
         end
      end
   end

   // one generator step
   assign lcg_prod = base * LCG_MUL + LCG_ADD;
   assign fib_a    = fib_once(base[FIB_W-1:0]);
   assign fib_b    = fib_once(fib_a);

   always_comb begin
      unique case (sel_ff)
         GEN_GALOIS: begin
            next_seed = (base >> 1) ^ (base[0] ? GALOIS_TAPS : '0);
            word      = next_seed;
         end
         GEN_LCG: begin
            next_seed = {1'b0, lcg_prod[WORD_W-2:0]};
            word      = next_seed;
         end
         default: begin
            next_seed = {{(WORD_W-FIB_W){1'b0}}, fib_b};
            word      = {fib_a, fib_b};
         end
      endcase
   end

   // selector and seed; a selector write also loads that generator's default seed
   always_comb begin
      sel_in  = sel_ff;
      seed_in = seed_ff;
      if (csr.valid && csr.ready) begin
         sel_in = gen_sel_type'(csr.data);
         unique case (gen_sel_type'(csr.data))
            GEN_GALOIS: seed_in = GALOIS_DEFAULT;
            GEN_LCG:    seed_in = LCG_DEFAULT;
            default:    seed_in = {{(WORD_W-FIB_W){1'b0}}, FIB_DEFAULT};
         endcase
      end else if (accept) begin
         seed_in = next_seed;
      end
   end

   // stage register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in.func  = req.func;
         s1_in.data  = req.data_in;
         s1_in.word  = word;
      end else if (stage_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff      <= GEN_GALOIS;
         seed_ff     <= GALOIS_DEFAULT;
         s1_valid_ff <= 1'b0;
      end else begin
         sel_ff      <= sel_in;
         seed_ff     <= seed_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign stage_valid = s1_valid_ff;
   assign stage       = s1_ff;

   // LCG state never carries bit 31
   a_lcg_width: assert property (@(posedge clock) disable iff (reset)
      (sel_ff == GEN_LCG) |-> !seed_ff[WORD_W-1])
      else $error("LCG seed has bit 31 set");

   // Fibonacci state stays within 16 bits
   a_fib_width: assert property (@(posedge clock) disable iff (reset)
      (sel_ff != GEN_GALOIS && sel_ff != GEN_LCG) |-> (seed_ff[WORD_W-1:FIB_W] == '0))
      else $error("Fibonacci seed wider than 16 bits");

   // a held stage transaction is not overwritten
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !stage_ready) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("stalled stage transaction changed");

   // seed moves only on an accepted transaction or a selector write
   a_seed_still: assert property (@(posedge clock) disable iff (reset)
      (!accept && !csr.valid) |=> $stable(seed_ff))
      else $error("seed changed without a transaction");

endmodule

// ===== rtl/core/pkbc_mix.sv =====
`timescale 1ns / 1ps

module pkbc_mix
   import pkbc_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   input  logic          stage_valid,
   input  stage_type     stage,
   output logic          stage_ready,
   pkbc_rsp_if.source    rsp
   );

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;

   logic [DATA_W+1:0] byte_sum;
   logic [DATA_W:0]   fold;
   logic [DATA_W-1:0] ks;

   // word mod 255: bytes add since 256 = 1 (mod 255), then one fold and correction
   assign byte_sum = {2'b00, stage.word[7:0]}   + {2'b00, stage.word[15:8]}
                   + {2'b00, stage.word[23:16]} + {2'b00, stage.word[31:24]};
   assign fold     = {1'b0, byte_sum[DATA_W-1:0]} + {{(DATA_W-1){1'b0}}, byte_sum[DATA_W+1:DATA_W]};

   always_comb begin
      if (fold >= {1'b0, KS_MODULUS}) begin
         ks = DATA_W'(fold - {1'b0, KS_MODULUS});
      end else begin
         ks = fold[DATA_W-1:0];
      end
   end

   // output register
   assign stage_ready = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (stage_ready) begin
         out_valid_in = stage_valid;
         if (stage_valid) begin
            out_data_in = (stage.func == FUNC_CRYPT) ? (stage.data ^ ks) : ks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.data_out = out_data_ff;

   // a moved stage transaction shows up on the output
   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && stage_ready) |=> out_valid_ff)
      else $error("stage transaction lost");

   // keystream byte never reaches the modulus
   a_ks_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid |-> (ks != KS_MODULUS))
      else $error("keystream byte out of range");

endmodule

// ===== rtl/core/prng_keystream_byte_cipher_top.sv =====
`timescale 1ns / 1ps

// Channel  Modport  Carries                                    Transaction
// req      sink     func, new_message, key[31:0], data_in[7:0] valid && ready
// rsp      source   data_out[7:0]                              valid && ready
// csr      sink     data[1:0] (generator_select)               valid && ready
//
// One byte per cycle sustained while rsp is ready; a request passes the stage register, then the output register.
// The limit is the seed feedback: key select, one generator step (LCG multiply) per cycle.
// Reset: Galois generator, seed 1; no pipeline contents. csr is always ready.
// A stalled response holds its byte; the generator stage still takes one more byte,
// then req.ready drops until the response is taken.

module prng_keystream_byte_cipher_top
   import pkbc_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   pkbc_req_if.sink    req_if,
   pkbc_rsp_if.source  rsp_if,
   pkbc_csr_if.sink    csr_if
   );

   logic      stage_valid;
   logic      stage_ready;
   stage_type stage;

   // seed, generator step, stage register
   pkbc_keygen u_keygen (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .csr         (csr_if),
      .stage_valid (stage_valid),
      .stage       (stage),
      .stage_ready (stage_ready)
   );

   // keystream byte and output register
   pkbc_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp         (rsp_if)
   );

endmodule

// ===== sim/prng_keystream_byte_cipher_top_tb.sv =====
`timescale 1ns / 1ps

module prng_keystream_byte_cipher_top_tb;
   import pkbc_pkg::*;

   // selector code with no generator of its own; behaves as the Fibonacci one
   localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

   localparam int QUIET_LIMIT   = 1000;
   localparam int MAX_SHOWN     = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BYTES   = 150;
   localparam int DRAIN_CYCLES  = 4;

   typedef enum logic {
      ROW_BYTE   = 1'b0,
      ROW_SELECT = 1'b1
   } row_kind_type;

   typedef enum logic [1:0] {
      HOLD_NONE   = 2'd0,
      HOLD_RANDOM = 2'd1,
      HOLD_THIRD  = 2'd2,
      HOLD_LONG   = 2'd3
   } hold_mode_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [SEL_W-1:0]  sel;
      func_type          func;
      logic              new_message;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic              known;      // expected byte given in the next column
      logic [DATA_W-1:0] known_out;
   } row_type;

   // directed table: reset state, zero seeds, key truncation, selector writes
   localparam row_type DIRECTED_ROWS [24] = '{
      '{ROW_BYTE,   GEN_GALOIS, FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b1, 8'hD1},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b0, 32'hFFFF_FFFF, 8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b1, 32'h0000_0000, 8'hA5, 1'b1, 8'hA5},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'h5A, 1'b1, 8'h5A},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_RANDOMIZE, 1'b1, 32'hFFFF_FFFF, 8'h00, 1'b1, 8'h00},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'hFF, 1'b0, 8'h00},
      '{ROW_SELECT, GEN_LCG,    FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_LCG,    FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b1, 8'h69},
      '{ROW_BYTE,   GEN_LCG,    FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_LCG,    FUNC_CRYPT,     1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_LCG,    FUNC_CRYPT,     1'b1, 32'h0000_0000, 8'h80, 1'b1, 8'hE9},
      '{ROW_SELECT, GEN_FIB,    FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_FIB,    FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_FIB,    FUNC_CRYPT,     1'b1, 32'hABCD_0000, 8'h3C, 1'b1, 8'h3C},
      '{ROW_BYTE,   GEN_FIB,    FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b1, 8'h00},
      '{ROW_BYTE,   GEN_FIB,    FUNC_CRYPT,     1'b1, 32'h0000_FFFF, 8'hFF, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_FIB,    FUNC_CRYPT,     1'b1, 32'hFFFF_FFFF, 8'h01, 1'b0, 8'h00},
      '{ROW_SELECT, SEL_SPARE,  FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   SEL_SPARE,  FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   SEL_SPARE,  FUNC_CRYPT,     1'b1, 32'h1234_5678, 8'h7E, 1'b0, 8'h00},
      '{ROW_SELECT, GEN_GALOIS, FUNC_CRYPT,     1'b0, 32'h0000_0000, 8'h00, 1'b0, 8'h00},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_RANDOMIZE, 1'b0, 32'h0000_0000, 8'h00, 1'b1, 8'hD1},
      '{ROW_BYTE,   GEN_GALOIS, FUNC_CRYPT,     1'b1, 32'h8000_0000, 8'h00, 1'b0, 8'h00}
   };

   logic clock;
   logic reset;

   pkbc_req_if req_ch ();
   pkbc_rsp_if rsp_ch ();
   pkbc_csr_if csr_ch ();

   prng_keystream_byte_cipher_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predicted generator state
   logic [SEL_W-1:0]  model_sel;
   logic [WORD_W-1:0] model_seed;

   // bytes still owed by the block, oldest first
   logic [DATA_W-1:0] expected_bytes [$];
   logic [DATA_W-1:0] head_byte;

   int error_count   = 0;
   int bytes_sent    = 0;
   int bytes_checked = 0;
   int select_writes = 0;
   int quiet_cycles  = 0;
   int burst_left    = 0;

   hold_mode_type hold_mode = HOLD_NONE;
   int            hold_left = 0;
   int            stall_run = 0;
   int            third_cnt = 0;

   // 100 MHz clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void log_error(input string msg);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("ERROR @%0t: %s", $time, msg);
   endfunction

   // 16-bit Fibonacci LFSR, taps 16 14 13 11
   function automatic logic [FIB_W-1:0] lfsr16_step(input logic [FIB_W-1:0] s);
      return {s[0] ^ s[2] ^ s[3] ^ s[5], s[FIB_W-1:1]};
   endfunction

   // selector write also restores that generator's default seed
   function automatic void load_generator(input logic [SEL_W-1:0] sel);
      model_sel = sel;
      case (sel)
         GEN_GALOIS: model_seed = GALOIS_DEFAULT;
         GEN_LCG:    model_seed = LCG_DEFAULT;
         default:    model_seed = {{(WORD_W-FIB_W){1'b0}}, FIB_DEFAULT};
      endcase
   endfunction

   // one generator step and the resulting output byte
   function automatic logic [DATA_W-1:0] cipher_byte(input func_type          func,
                                                     input logic              new_message,
                                                     input logic [KEY_W-1:0]  key,
                                                     input logic [DATA_W-1:0] data);
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] rem;
      logic [FIB_W-1:0]  fib_hi;
      logic [FIB_W-1:0]  fib_lo;
      logic [DATA_W-1:0] ks;
      // reseed on a crypt message start; Fibonacci keeps only 16 bits
      if (func == FUNC_CRYPT && new_message) begin
         if (model_sel == GEN_GALOIS || model_sel == GEN_LCG)
            model_seed = key;
         else
            model_seed = {{(WORD_W-FIB_W){1'b0}}, key[FIB_W-1:0]};
      end
      case (model_sel)
         GEN_GALOIS: begin
            word = model_seed >> 1;
            if (model_seed[0])
               word = word ^ GALOIS_TAPS;
            model_seed = word;
         end
         GEN_LCG: begin
            word = model_seed * LCG_MUL + LCG_ADD;
            word[WORD_W-1] = 1'b0;
            model_seed = word;
         end
         default: begin
            fib_hi = lfsr16_step(model_seed[FIB_W-1:0]);
            fib_lo = lfsr16_step(fib_hi);
            model_seed = {{(WORD_W-FIB_W){1'b0}}, fib_lo};
            word = {fib_hi, fib_lo};
         end
      endcase
      rem = word % KS_MODULUS;
      ks = rem[DATA_W-1:0];
      return (func == FUNC_CRYPT) ? (data ^ ks) : ks;
   endfunction

   // keys lean towards the corners: zero, all ones, 16-bit only
   function automatic logic [KEY_W-1:0] random_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom & 32'h0000_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // one request transaction; sender may idle between bursts
   task automatic send_byte(input func_type          func,
                            input logic              new_message,
                            input logic [KEY_W-1:0]  key,
                            input logic [DATA_W-1:0] data,
                            input logic              known,
                            input logic [DATA_W-1:0] known_out);
      int                gap;
      logic [DATA_W-1:0] predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.new_message <= new_message;
      req_ch.key         <= key;
      req_ch.data_in     <= data;
      do @(posedge clock); while (!req_ch.ready);
      predicted = cipher_byte(func, new_message, key, data);
      expected_bytes.push_back(known ? known_out : predicted);
      bytes_sent++;
   endtask

   // register write, only once every owed byte has come out
   task automatic write_generator(input logic [SEL_W-1:0] sel);
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= sel;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      load_generator(sel);
      select_writes++;
   endtask

   // response check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_bytes.size() == 0) begin
            log_error($sformatf("data_out %02h with no byte pending", rsp_ch.data_out));
         end else begin
            head_byte = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_ch.data_out !== head_byte)
               log_error($sformatf("data_out expected %02h, got %02h",
                                   head_byte, rsp_ch.data_out));
         end
      end
   end

   // receiver back-pressure: a new stall mode is drawn whenever the current one runs out
   always @(posedge clock) begin
      if (hold_left == 0) begin
         hold_mode = hold_mode_type'($urandom_range(0, 3));
         hold_left = $urandom_range(30, 150);
      end
      hold_left--;
      third_cnt = (third_cnt == 2) ? 0 : third_cnt + 1;
      case (hold_mode)
         HOLD_NONE:   rsp_ch.ready <= 1'b1;
         HOLD_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
         HOLD_THIRD:  rsp_ch.ready <= (third_cnt != 0);
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 4) == 0)
                  stall_run = $urandom_range(1, 12);
            end
         end
      endcase
   end

   // cycles without any transaction on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // watchdog
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Watchdog: no transaction for %0d cycles, %0d bytes pending",
               QUIET_LIMIT, expected_bytes.size());
      $display("DONE: errors detected");
      $finish;
   end

   // stimulus
   initial begin
      row_type          row;
      logic [SEL_W-1:0] phase_sel;
      logic [KEY_W-1:0] msg_key;
      int               phase_count;
      int               kind;
      int               msg_len;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = FUNC_CRYPT;
      req_ch.new_message = 1'b0;
      req_ch.key         = '0;
      req_ch.data_in     = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.data        = GEN_GALOIS;
      load_generator(GEN_GALOIS);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_SELECT)
            write_generator(row.sel);
         else
            send_byte(row.func, row.new_message, row.key, row.data, row.known, row.known_out);
      end

      // random phases, each under its own generator
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       phase_sel = GEN_LCG;
            1:       phase_sel = GEN_FIB;
            2:       phase_sel = SEL_SPARE;
            3:       phase_sel = GEN_GALOIS;
            default: phase_sel = SEL_W'($urandom_range(0, 3));
         endcase
         write_generator(phase_sel);
         phase_count = 0;
         while (phase_count < PHASE_BYTES) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               // well-formed crypt message: reseed on the first byte only
               msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                      : $urandom_range(1, 12);
               msg_key = random_key();
               for (int b = 0; b < msg_len; b++)
                  send_byte(FUNC_CRYPT, (b == 0), msg_key, DATA_W'($urandom_range(0, 255)),
                            1'b0, 8'h00);
               phase_count += msg_len;
            end else if (kind == 7) begin
               // randomize: message flag and key must have no effect
               send_byte(FUNC_RANDOMIZE, 1'($urandom_range(0, 1)), $urandom,
                         DATA_W'($urandom_range(0, 255)), 1'b0, 8'h00);
               phase_count++;
            end else begin
               // stray crypt byte, message flag at random
               send_byte(FUNC_CRYPT, 1'($urandom_range(0, 1)), random_key(),
                         DATA_W'($urandom_range(0, 255)), 1'b0, 8'h00);
               phase_count++;
            end
         end
      end

      // drain and settle
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d directed), checked %0d, mismatches %0d",
               bytes_sent, $size(DIRECTED_ROWS) - 4, bytes_checked, error_count);
      $display("Covered %0d generator selections incl. the spare code, crypt and randomize",
               select_writes);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
